FILE: sv/sacp_pkg.sv
package sacp_pkg;

	localparam int unsigned ENTRIES = 64;
	localparam int unsigned AW = $clog2(ENTRIES);
	localparam int unsigned CW = $clog2(ENTRIES + 1);

	localparam logic [39:0] CAPACITY_RESET = 40'd5368709120;
	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	localparam int unsigned IN_W = 64;
	localparam int unsigned OUT_W = 232;

	// one table entry as held in memory
	typedef struct packed {
		logic [31:0] cnt;
		logic [31:0] size;
		logic [31:0] id;
	} entry_t;

endpackage

FILE: sv/sacp_ram.sv
module sacp_ram #(
	parameter int unsigned DW = 96,
	parameter int unsigned AW = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/size_aware_lfu_cache_policy_unit.sv
// Channel   Direction  Transaction contents
// s_axis    in         object_id, object_size
// m_axis    out        hit, admitted, evictions, running counters
// cfg       in         capacity_bytes (write only)
//
// A request scans all ENTRIES slots of the entry RAM once, then passes through control
// states to the result. Each eviction adds another full scan of the table plus its
// eviction and decision states.
// The single RAM read port makes these scans serial; one request is in work at a time.
// Reset clears valid bits, occupancy and counters; the RAM needs no clearing.
// A result held in the output register stalls only the next request's finish.
module size_aware_lfu_cache_policy_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// object_id [31:0], object_size [63:32]
	input  logic [sacp_pkg::IN_W-1:0]   s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// hit [0], admitted [1], evictions [8:2], total_requests [56:9],
	// hit_requests [104:57], total_bytes [167:105], hit_bytes_sum [230:168]
	output logic [sacp_pkg::OUT_W-1:0]  m_axis_tdata,
	input  logic                        cfg_we,
	input  logic [39:0]                 cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOOK, ST_HITWR, ST_DECIDE, ST_VICT, ST_EVICT, ST_INSERT, ST_RESULT
	} state_t;

	state_t state_q;

	logic [39:0] cap_q;
	logic [31:0] id_q, size_q;
	logic [sacp_pkg::CW-1:0] idx_q, vcount_q;
	logic rd_v_s1;
	logic [sacp_pkg::AW-1:0] rd_idx_s1;
	logic [sacp_pkg::ENTRIES-1:0] valid_q;

	logic found_q, free_v_q, best_v_q, hit_q, adm_q;
	logic [sacp_pkg::AW-1:0] slot_q, free_q, best_q;
	sacp_pkg::entry_t hit_ent_q, best_ent_q;
	logic [39:0] occ_q;
	logic [6:0] evict_q;

	logic [47:0] req_cnt_q, hit_cnt_q;
	logic [62:0] byte_cnt_q, hit_byte_q;

	logic out_v_q;
	logic [sacp_pkg::OUT_W-1:0] out_q;

	logic ram_we;
	logic [sacp_pkg::AW-1:0] ram_waddr, ram_raddr;
	sacp_pkg::entry_t ram_wdata, ram_rdata;

	sacp_ram #(
		.DW($bits(sacp_pkg::entry_t)),
		.AW(sacp_pkg::AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	logic scan_issue, scan_done, better, over, full;
	logic [47:0] req_nx, hit_nx;
	logic [62:0] byte_nx, hbyte_nx;

	// scan control and decision terms
	always_comb begin
		scan_issue = (idx_q != sacp_pkg::CW'(sacp_pkg::ENTRIES));
		scan_done = !scan_issue && !rd_v_s1;
		ram_raddr = idx_q[sacp_pkg::AW-1:0];
		better = !best_v_q || (ram_rdata.cnt < best_ent_q.cnt) ||
			((ram_rdata.cnt == best_ent_q.cnt) &&
			 ((ram_rdata.size > best_ent_q.size) ||
			  ((ram_rdata.size == best_ent_q.size) && (ram_rdata.id < best_ent_q.id))));
		over = ({1'b0, occ_q} + {9'd0, size_q}) > {1'b0, cap_q};
		full = (vcount_q == sacp_pkg::CW'(sacp_pkg::ENTRIES));
		req_nx = req_cnt_q + 48'd1;
		byte_nx = byte_cnt_q + {31'd0, size_q};
		hit_nx = hit_q ? hit_cnt_q + 48'd1 : hit_cnt_q;
		hbyte_nx = hit_q ? hit_byte_q + {31'd0, size_q} : hit_byte_q;
	end

	// entry RAM writes: count update on a hit, new entry on an insert
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = slot_q;
		ram_wdata = hit_ent_q;
		if (state_q == ST_HITWR) begin
			ram_we = 1'b1;
			ram_wdata.cnt = (hit_ent_q.cnt == sacp_pkg::COUNT_MAX) ?
				hit_ent_q.cnt : hit_ent_q.cnt + 32'd1;
		end else if (state_q == ST_INSERT) begin
			ram_we = 1'b1;
			ram_waddr = free_q;
			ram_wdata.id = id_q;
			ram_wdata.size = size_q;
			ram_wdata.cnt = '0;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = out_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= sacp_pkg::CAPACITY_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			rd_v_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			valid_q <= '0;
			vcount_q <= '0;
			occ_q <= '0;
			found_q <= 1'b0;
			free_v_q <= 1'b0;
			best_v_q <= 1'b0;
			hit_q <= 1'b0;
			adm_q <= 1'b0;
			evict_q <= '0;
			req_cnt_q <= '0;
			hit_cnt_q <= '0;
			byte_cnt_q <= '0;
			hit_byte_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			// drop the output once taken; the result state reloads it itself
			if (out_v_q && m_axis_tready && (state_q != ST_RESULT)) begin
				out_v_q <= 1'b0;
			end

			// advance the read pipeline during scans
			if ((state_q == ST_LOOK) || (state_q == ST_VICT)) begin
				rd_v_s1 <= scan_issue;
				rd_idx_s1 <= idx_q[sacp_pkg::AW-1:0];
				if (scan_issue) begin
					idx_q <= idx_q + sacp_pkg::CW'(1);
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						id_q <= s_axis_tdata[31:0];
						size_q <= s_axis_tdata[63:32];
						idx_q <= '0;
						found_q <= 1'b0;
						free_v_q <= 1'b0;
						hit_q <= 1'b0;
						adm_q <= 1'b0;
						evict_q <= '0;
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (rd_v_s1) begin
						if (valid_q[rd_idx_s1] && (ram_rdata.id == id_q) && !found_q) begin
							found_q <= 1'b1;
							slot_q <= rd_idx_s1;
							hit_ent_q <= ram_rdata;
						end
						if (!valid_q[rd_idx_s1] && !free_v_q) begin
							free_v_q <= 1'b1;
							free_q <= rd_idx_s1;
						end
					end
					if (scan_done) begin
						if (found_q) begin
							state_q <= ST_HITWR;
						end else if ({8'd0, size_q} < cap_q) begin
							state_q <= ST_DECIDE;
						end else begin
							state_q <= ST_RESULT;
						end
					end
				end
				ST_HITWR: begin
					hit_q <= 1'b1;
					state_q <= ST_RESULT;
				end
				ST_DECIDE: begin
					if ((over || full) && (vcount_q != '0)) begin
						idx_q <= '0;
						best_v_q <= 1'b0;
						state_q <= ST_VICT;
					end else if (full || !free_v_q) begin
						state_q <= ST_RESULT;
					end else begin
						state_q <= ST_INSERT;
					end
				end
				ST_VICT: begin
					if (rd_v_s1 && valid_q[rd_idx_s1] && better) begin
						best_v_q <= 1'b1;
						best_q <= rd_idx_s1;
						best_ent_q <= ram_rdata;
					end
					if (scan_done) begin
						state_q <= ST_EVICT;
					end
				end
				ST_EVICT: begin
					valid_q[best_q] <= 1'b0;
					vcount_q <= vcount_q - sacp_pkg::CW'(1);
					occ_q <= occ_q - {8'd0, best_ent_q.size};
					evict_q <= evict_q + 7'd1;
					if (!free_v_q || (best_q < free_q)) begin
						free_v_q <= 1'b1;
						free_q <= best_q;
					end
					state_q <= ST_DECIDE;
				end
				ST_INSERT: begin
					valid_q[free_q] <= 1'b1;
					vcount_q <= vcount_q + sacp_pkg::CW'(1);
					occ_q <= occ_q + {8'd0, size_q};
					adm_q <= 1'b1;
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (!out_v_q || m_axis_tready) begin
						req_cnt_q <= req_nx;
						byte_cnt_q <= byte_nx;
						hit_cnt_q <= hit_nx;
						hit_byte_q <= hbyte_nx;
						out_q <= {1'b0, hbyte_nx, byte_nx, hit_nx, req_nx, evict_q, adm_q, hit_q};
						out_v_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_vcount_range: assert property (@(posedge clk) disable iff (!arst_n)
		vcount_q <= sacp_pkg::CW'(sacp_pkg::ENTRIES))
		else $error("valid count beyond table size");
	a_hit_no_admit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT) |-> !(hit_q && adm_q))
		else $error("hit and admission together");
	a_evict_has_victim: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVICT) |-> best_v_q)
		else $error("eviction without a victim");
	a_insert_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INSERT) |=> valid_q[$past(free_q)])
		else $error("inserted slot not valid");
`endif

endmodule

FILE: tb/sv/lfu_policy_checker.sv
module lfu_policy_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	input  logic                       s_axis_tready,
	input  logic [sacp_pkg::IN_W-1:0]  s_axis_tdata,
	input  logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	input  logic [sacp_pkg::OUT_W-1:0] m_axis_tdata,
	input  logic                       cfg_we,
	input  logic [39:0]                cfg_wdata,
	output int                         mismatches,
	output int                         outstanding
);

	typedef struct packed {
		logic [62:0] hbyte_total;
		logic [62:0] bytes;
		logic [47:0] hit_reqs;
		logic [47:0] reqs;
		logic [6:0]  evicted;
		logic        admitted;
		logic        hit;
	} policy_result_t;

	// shadow copy of the cache table and counters
	logic        slot_valid [sacp_pkg::ENTRIES];
	logic [31:0] slot_id    [sacp_pkg::ENTRIES];
	logic [31:0] slot_size  [sacp_pkg::ENTRIES];
	logic [31:0] slot_count [sacp_pkg::ENTRIES];
	logic [39:0] occupied;
	logic [39:0] capacity;
	logic [47:0] req_cnt;
	logic [47:0] hit_cnt;
	logic [62:0] byte_cnt;
	logic [62:0] hit_byte_cnt;

	policy_result_t pending_results[$];

	function automatic int first_free_slot();
		for (int i = 0; i < sacp_pkg::ENTRIES; i++)
			if (!slot_valid[i])
				return i;
		return -1;
	endfunction

	// least count, then largest size, then lowest id
	function automatic int lfu_victim();
		int best;
		best = -1;
		for (int i = 0; i < sacp_pkg::ENTRIES; i++) begin
			if (!slot_valid[i])
				continue;
			if (best < 0)
				best = i;
			else if (slot_count[i] < slot_count[best] ||
					(slot_count[i] == slot_count[best] &&
					(slot_size[i] > slot_size[best] ||
					(slot_size[i] == slot_size[best] && slot_id[i] < slot_id[best]))))
				best = i;
		end
		return best;
	endfunction

	function automatic policy_result_t apply_request(logic [31:0] id, logic [31:0] size);
		policy_result_t r;
		int slot;
		int victim;
		int unsigned evicted;
		r = '0;
		slot = -1;
		evicted = 0;
		req_cnt = req_cnt + 48'd1;
		byte_cnt = byte_cnt + 63'(size);
		for (int i = 0; i < sacp_pkg::ENTRIES; i++)
			if (slot < 0 && slot_valid[i] && slot_id[i] == id)
				slot = i;
		if (slot >= 0) begin
			r.hit = 1'b1;
			hit_cnt = hit_cnt + 48'd1;
			hit_byte_cnt = hit_byte_cnt + 63'(size);
			if (slot_count[slot] != sacp_pkg::COUNT_MAX)
				slot_count[slot] = slot_count[slot] + 32'd1;
		end else if (40'(size) < capacity) begin
			// evict until the object fits and a slot is free
			forever begin
				if (64'(occupied) + 64'(size) <= 64'(capacity) && first_free_slot() >= 0)
					break;
				victim = lfu_victim();
				if (victim < 0)
					break;
				slot_valid[victim] = 1'b0;
				occupied = occupied - 40'(slot_size[victim]);
				evicted++;
			end
			slot = first_free_slot();
			if (slot >= 0) begin
				slot_valid[slot] = 1'b1;
				slot_id[slot] = id;
				slot_size[slot] = size;
				slot_count[slot] = '0;
				occupied = occupied + 40'(size);
				r.admitted = 1'b1;
			end
		end
		r.evicted = 7'(evicted);
		r.reqs = req_cnt;
		r.hit_reqs = hit_cnt;
		r.bytes = byte_cnt;
		r.hbyte_total = hit_byte_cnt;
		return r;
	endfunction

	assign outstanding = pending_results.size();

	// track config writes, predict on requests, compare on results
	always @(posedge clk or negedge arst_n) begin
		policy_result_t exp_r;
		policy_result_t got_r;
		if (!arst_n) begin
			for (int i = 0; i < sacp_pkg::ENTRIES; i++)
				slot_valid[i] = 1'b0;
			occupied = '0;
			capacity = sacp_pkg::CAPACITY_RESET;
			req_cnt = '0;
			hit_cnt = '0;
			byte_cnt = '0;
			hit_byte_cnt = '0;
			pending_results.delete();
			mismatches = 0;
		end else begin
			if (cfg_we)
				capacity = cfg_wdata;
			if (s_axis_tvalid && s_axis_tready)
				pending_results.push_back(apply_request(s_axis_tdata[31:0],
					s_axis_tdata[63:32]));
			if (m_axis_tvalid && m_axis_tready) begin
				got_r = policy_result_t'(m_axis_tdata[230:0]);
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transaction: %h", got_r);
				end else begin
					exp_r = pending_results.pop_front();
					if (got_r != exp_r) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("result mismatch at request %0d", exp_r.reqs);
							$display("  hit %b/%b admitted %b/%b evictions %0d/%0d",
								exp_r.hit, got_r.hit, exp_r.admitted, got_r.admitted,
								exp_r.evicted, got_r.evicted);
							$display("  requests %0d/%0d hits %0d/%0d",
								exp_r.reqs, got_r.reqs, exp_r.hit_reqs, got_r.hit_reqs);
							$display("  bytes %0d/%0d hit bytes %0d/%0d",
								exp_r.bytes, got_r.bytes, exp_r.hbyte_total,
								got_r.hbyte_total);
						end
					end
				end
			end
		end
	end

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;

	localparam int CYCLE_LIMIT = 40000000;

	logic                       clk;
	logic                       arst_n;
	logic                       s_axis_tvalid;
	logic                       s_axis_tready;
	logic [sacp_pkg::IN_W-1:0]  s_axis_tdata;
	logic                       m_axis_tvalid;
	logic                       m_axis_tready;
	logic [sacp_pkg::OUT_W-1:0] m_axis_tdata;
	logic                       cfg_we;
	logic [39:0]                cfg_wdata;
	int                         mismatches;
	int                         outstanding;
	int                         cycles;
	int                         ready_hold;
	int unsigned                id_pool;
	int unsigned                size_cap;
	logic [39:0]                capacities [6];

	size_aware_lfu_cache_policy_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	lfu_policy_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// stall the result side in random stretches
	always @(posedge clk) begin
		if (ready_hold > 0)
			ready_hold <= ready_hold - 1;
		else begin
			m_axis_tready <= $urandom_range(0, 2) != 0;
			ready_hold <= idle_len();
		end
	end

	// abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// drive one request; valid stays up across back-to-back transactions
	task automatic send_request(logic [31:0] id, logic [31:0] size);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {size, id};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// write capacity only once the block is drained
	task automatic set_capacity(logic [39:0] value);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_id();
		if ($urandom_range(0, 19) == 0)
			return $urandom();
		return 32'h1000_0000 + $urandom_range(0, id_pool - 1);
	endfunction

	function automatic logic [31:0] pick_size();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, size_cap);
		if (r < 90)
			return $urandom_range(1, 32'hFFFF_FFFF);
		if (r < 95)
			return 32'hFFFF_FFFF;
		return 32'd1;
	endfunction

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		cycles = 0;
		ready_hold = 0;
		id_pool = 8;
		size_cap = 100;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes at the reset capacity
		send_request(32'h0000_0000, 32'd1);
		send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(32'h0000_0000, 32'd7);
		send_request(32'hFFFF_FFFF, 32'd1);
		send_request(32'hA5A5_5A5A, 32'h5A5A_A5A5);
		// small capacity: bypass at the limit, admit just below, forced evictions
		set_capacity(40'd100);
		send_request(32'd1, 32'd100);
		send_request(32'd2, 32'd99);
		send_request(32'd3, 32'd1);
		send_request(32'd4, 32'd50);
		send_request(32'd4, 32'd50);
		send_request(32'd5, 32'd50);
		send_request(32'd6, 32'd50);
		// lowered capacity keeps entries until the next admitted miss
		set_capacity(40'd10);
		send_request(32'd6, 32'd50);
		send_request(32'd7, 32'd3);
		// zero capacity bypasses every miss; an entry still cached still hits
		set_capacity(40'd0);
		send_request(32'd8, 32'd1);
		send_request(32'd7, 32'd3);
		// widest capacity
		set_capacity(40'hFF_FFFF_FFFF);
		send_request(32'd9, 32'hFFFF_FFFF);
		send_request(32'd9, 32'd2);

		// random phases over several capacities and id pools
		capacities[0] = sacp_pkg::CAPACITY_RESET;
		capacities[1] = 40'd1000;
		capacities[2] = 40'hFF_FFFF_FFFF;
		capacities[3] = 40'd0;
		capacities[4] = {$urandom(), 8'($urandom())};
		capacities[5] = 40'd200;
		for (int p = 0; p < 6; p++) begin
			set_capacity(capacities[p]);
			case (p)
				0: begin id_pool = 100; size_cap = 32'h7FFF_FFFF; end
				1: begin id_pool = 90;  size_cap = 20; end
				2: begin id_pool = 12;  size_cap = 1000; end
				3: begin id_pool = 16;  size_cap = 50; end
				4: begin id_pool = 70;  size_cap = 32'hFFFF_FFFF; end
				default: begin id_pool = 8; size_cap = 60; end
			endcase
			for (int n = 0; n < 240; n++)
				send_request(pick_id(), pick_size());
			// flood small entries, then one large miss that sweeps the table
			if (p == 1) begin
				set_capacity(40'd1000);
				for (int k = 0; k < 64; k++)
					send_request(32'h2000_0000 + k, 32'd10);
				send_request(32'h3000_0000, 32'd999);
			end
		end

		s_axis_tvalid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
